// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the chorus delay RTL.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cmd_pkg.sv =====
// Package for the chorus modulated delay: widths, word types, register codes
// and the sine table generator. No dependencies.
package cmd_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int FRAME_W          = 2 * SAMPLE_W;
  localparam int MEAN_W           = 11;
  localparam int SWING_W          = 11;
  localparam int PHASE_W          = 32;
  localparam int SINE_W           = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;
  localparam int DEPTH_DEF        = 4096;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam logic [MEAN_W-1:0]  MEAN_RST  = MEAN_W'(512);
  localparam logic [SWING_W-1:0] SWING_RST = SWING_W'(128);
  localparam logic [PHASE_W-1:0] STEP_RST  = PHASE_W'(4000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_MEAN  = 2'd0,
    CFG_DELAY_SWING = 2'd1,
    CFG_PHASE_STEP  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } frame_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } frame_out_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  delay_mean;
    logic [SWING_W-1:0] delay_swing;
    logic [PHASE_W-1:0] phase_step;
  } cmd_cfg_t;

  // Quarter-wave polynomial, Q15 in and out.
  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x2 = (x * x) >> 15;
    t  = 64'd21024 - ((64'd2320 * x2) >> 15);
    t  = 64'd51472 - ((t * x2) >> 15);
    y  = (t * x) >> 15;
    return (y > 64'd32767) ? 64'd32767 : y;
  endfunction

  // Table entry idx of a 2^lg entry full-cycle sine, Q1.15.
  function automatic logic signed [SINE_W-1:0] sine_entry(int idx, int lg);
    longint unsigned i4;
    longint unsigned q;
    longint unsigned x;
    longint unsigned v;
    i4 = 64'(idx) * 64'd4;
    q  = i4 >> lg;
    x  = ((i4 & ((64'd1 << lg) - 64'd1)) << 15) >> lg;
    if (q[0]) begin
      x = 64'd32768 - x;
    end
    v = quarter_wave(x);
    return q[1] ? -SINE_W'(v) : SINE_W'(v);
  endfunction

endpackage

// ===== hw/rtl/cmd_cfg_regs.sv =====
// Configuration registers of the chorus delay: mean, swing and phase step.
// Depends on cmd_pkg.
module cmd_cfg_regs
  import cmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cmd_cfg_t              cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_mean  <= MEAN_RST;
      cfg.delay_swing <= SWING_RST;
      cfg.phase_step  <= STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELAY_MEAN:  cfg.delay_mean  <= cfg_data[MEAN_W-1:0];
        CFG_DELAY_SWING: cfg.delay_swing <= cfg_data[SWING_W-1:0];
        CFG_PHASE_STEP:  cfg.phase_step  <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cmd_sine_rom.sv =====
// Sine ROM, Q1.15, built at elaboration, registered read.
// Depends on cmd_pkg for the entry generator.
module cmd_sine_rom
  import cmd_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [$clog2(SINE_ENTRIES)-1:0]  addr,
  output logic signed [SINE_W-1:0]         rd_data
);

  localparam int SINE_LG = $clog2(SINE_ENTRIES);

  logic signed [SINE_W-1:0] rom [SINE_ENTRIES];

  for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
    localparam logic signed [SINE_W-1:0] VAL = sine_entry(i, SINE_LG);
    assign rom[i] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= rom[addr];
    end
  end

endmodule

// ===== hw/rtl/cmd_delay_ram.sv =====
// Delay store: one write port, one read port, registered read data.
// Depends on cmd_pkg for the frame width.
module cmd_delay_ram
  import cmd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [FRAME_W-1:0]        wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [FRAME_W-1:0]        rd_data
);

  logic [FRAME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Same-address read returns old data; the caller never uses it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/chorus_modulated_delay_top.sv =====
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall   in_data   (frame_in_t)
// out      out  out_valid/out_stall out_data  (frame_out_t)
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
// One frame per cycle sustained while out_stall is low; out_valid follows the accepting
// edge through the stages sine ROM, multiply, delay RAM read and output register.
// Throughput is set by the single write/read port pair of the delay RAM.
// Reset: synchronous; the store is not swept, a wrap flag masks unwritten frames.
// Stalls back up stage by stage; empty stages still take new frames.
//
// Chorus modulated delay, top level: phase/pointer state and 4-stage pipeline.
// Depends on cmd_pkg, cmd_cfg_regs, cmd_sine_rom, cmd_delay_ram.
`include "assert_macros.svh"

module chorus_modulated_delay_top
  import cmd_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  frame_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output frame_out_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int SLG    = $clog2(SINE_ENTRIES);
  localparam int PROD_W = SWING_W + 1 + SINE_W;
  localparam int MOD_W  = PROD_W - 15;
  localparam int DLY_W  = (AW + 1 > MEAN_W + 2) ? AW + 1 : MEAN_W + 2;
  localparam logic [AW-1:0]  LAST = AW'(DEPTH - 1);
  localparam logic signed [DLY_W-1:0] DLY_MAX = DLY_W'(DEPTH - 1);
  localparam logic signed [SAMPLE_W:0] SMAX = (SAMPLE_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W:0] SMIN = -SMAX - (SAMPLE_W + 1)'(1);

  cmd_cfg_t cfg;

  cmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline occupancy and flow.
  logic s1_valid, s2_valid, s3_valid;
  logic ready1, ready2, ready3, ready4;
  logic in_acc;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !s3_valid || ready4;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;
  assign in_acc   = in_valid && ready1;

  // Per-frame state.
  logic [AW-1:0]      wp;
  logic [AW-1:0]      wp_next;
  logic               wrapped;
  logic [PHASE_W-1:0] phase;

  assign wp_next = (wp == LAST) ? '0 : wp + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      phase   <= '0;
    end else if (in_acc) begin
      wp    <= wp_next;
      phase <= phase + cfg.phase_step;
      if (wp == LAST) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Stage 1: sine lookup.
  frame_in_t                s1_frame;
  logic [AW-1:0]            s1_wp;
  logic                     s1_wrapped;
  logic signed [SINE_W-1:0] s1_sine;

  cmd_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine (
    .clk     (clk),
    .en      (ready1),
    .addr    (phase[PHASE_W-1 -: SLG]),
    .rd_data (s1_sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_frame   <= in_data;
      s1_wp      <= wp;
      s1_wrapped <= wrapped;
    end
  end

  // Stage 2: swing times sine.
  frame_in_t                s2_frame;
  logic [AW-1:0]            s2_wp;
  logic                     s2_wrapped;
  logic signed [PROD_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_frame   <= s1_frame;
      s2_wp      <= s1_wp;
      s2_wrapped <= s1_wrapped;
      s2_prod    <= $signed({1'b0, cfg.delay_swing}) * s1_sine;
    end
  end

  // Stage 2 combinational: delay, read address, RAM access.
  logic signed [MOD_W-1:0] s2_mod;
  logic signed [DLY_W-1:0] s2_dly_raw;
  logic [AW-1:0]           s2_dly;
  logic [AW-1:0]           s2_rd;
  logic [AW:0]             s2_rd_wrap;
  logic                    s2_bypass;
  logic                    s2_rd_ok;
  logic                    s2_xfer;

  // Arithmetic shift floors, matching the rounding of negative products.
  assign s2_mod     = MOD_W'(s2_prod >>> 15);
  assign s2_dly_raw = $signed(DLY_W'(cfg.delay_mean)) + DLY_W'(s2_mod);

  always_comb begin
    if (s2_dly_raw < 0) begin
      s2_dly = '0;
    end else if (s2_dly_raw > DLY_MAX) begin
      s2_dly = LAST;
    end else begin
      s2_dly = s2_dly_raw[AW-1:0];
    end
  end

  assign s2_rd_wrap = {1'b0, s2_wp} + (AW + 1)'(DEPTH) - {1'b0, s2_dly};
  assign s2_rd      = (s2_wp >= s2_dly) ? s2_wp - s2_dly : s2_rd_wrap[AW-1:0];
  assign s2_bypass  = (s2_dly == '0);
  assign s2_rd_ok   = s2_wrapped || (s2_dly <= s2_wp);
  assign s2_xfer    = s2_valid && ready3;

  logic [FRAME_W-1:0] s3_ram;

  cmd_delay_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s2_xfer),
    .wr_addr (s2_wp),
    .wr_data (s2_frame),
    .rd_en   (ready3),
    .rd_addr (s2_rd),
    .rd_data (s3_ram)
  );

  // Stage 3: pick delayed frame, sum and saturate.
  frame_in_t s3_frame;
  logic      s3_bypass;
  logic      s3_rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_frame  <= s2_frame;
      s3_bypass <= s2_bypass;
      s3_rd_ok  <= s2_rd_ok;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] sat_add(logic signed [SAMPLE_W-1:0] a,
                                                         logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] s;
    s = $signed({a[SAMPLE_W-1], a}) + $signed({b[SAMPLE_W-1], b});
    if (s > SMAX) begin
      return SMAX[SAMPLE_W-1:0];
    end else if (s < SMIN) begin
      return SMIN[SAMPLE_W-1:0];
    end
    return s[SAMPLE_W-1:0];
  endfunction

  frame_in_t  s3_dly;
  frame_out_t s3_sum;

  always_comb begin
    if (s3_bypass) begin
      s3_dly = s3_frame;
    end else if (s3_rd_ok) begin
      s3_dly = s3_ram;
    end else begin
      s3_dly = '0;
    end
    s3_sum.left_out  = sat_add(s3_frame.left_in, s3_dly.left_in);
    s3_sum.right_out = sat_add(s3_frame.right_in, s3_dly.right_in);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      out_data <= s3_sum;
    end
  end

  `CMD_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !s1_valid && (wp == '0) && !wrapped), "reset left pipeline or pointer state")
  `CMD_ASSERT(a_accept_enters, in_acc |=> s1_valid, "accepted frame did not enter stage 1")
  `CMD_ASSERT(a_rd_distinct, (s2_valid && !s2_bypass) |-> (s2_rd != s2_wp), "nonzero delay reads the entry being written")
  `CMD_ASSERT(a_unwritten_masked, (s2_valid && !s2_wrapped && !s2_bypass && s2_rd_ok) |-> (s2_rd < s2_wp), "read of a never-written entry not masked")

endmodule
